FILE: sv/dsmf_pkg.sv
// ----------------------------------------------------------------------------
// dsmf_pkg
// Shared constants and types of the dual sonar median filter.
// ----------------------------------------------------------------------------
package dsmf_pkg;

  // Window depth of each side and sample width
  localparam int WINDOW   = 5;
  localparam int SAMPLE_W = 8;

  // Width of the rank of an element in a window
  localparam int RANK_W = $clog2(WINDOW);

  localparam logic [SAMPLE_W-1:0] FILL_VALUE  = SAMPLE_W'(15);
  localparam logic [SAMPLE_W-1:0] CLAMP_RESET = SAMPLE_W'(100);

  typedef logic [SAMPLE_W-1:0] sample_t;

  // What one lane reports to the merge stage
  typedef struct packed {
    sample_t median;
    sample_t newest;
    sample_t previous;
  } lane_res_t;

endpackage

FILE: sv/dsmf_sample_if.sv
// ----------------------------------------------------------------------------
// dsmf_sample_if
// Input channel: one left and one right distance sample per item.
// ----------------------------------------------------------------------------
interface dsmf_sample_if import dsmf_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

FILE: sv/dsmf_result_if.sv
// ----------------------------------------------------------------------------
// dsmf_result_if
// Output channel: both medians and the steering and movement flags per item.
// ----------------------------------------------------------------------------
interface dsmf_result_if import dsmf_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t left_median;
  sample_t right_median;
  logic    steer_flag;
  logic    move_flag;

  modport source (
    output valid, output left_median, output right_median,
    output steer_flag, output move_flag, input ready
  );
  modport sink (
    input valid, input left_median, input right_median,
    input steer_flag, input move_flag, output ready
  );
endinterface

FILE: sv/dsmf_lane.sv
// ----------------------------------------------------------------------------
// dsmf_lane
// One side of the filter: clamp the sample, shift it into the window and
// pick the median by a rank compare network.
// ----------------------------------------------------------------------------
module dsmf_lane import dsmf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      shift_en,
  input  sample_t   sample,
  input  sample_t   clamp_limit,
  output lane_res_t res
);

  localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(WINDOW / 2);

  // Newest entry at index 0; the entry dropped is the oldest one
  sample_t            win [WINDOW];
  sample_t            clamped;
  logic [RANK_W-1:0]  rank [WINDOW];
  sample_t            median;

  // Clamp the raw sample to the limit
  assign clamped = (sample >= clamp_limit) ? clamp_limit : sample;

  // Advance the window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        win[k] <= FILL_VALUE;
      end
    end else if (shift_en) begin
      win[0] <= clamped;
      for (int k = 1; k < WINDOW; k++) begin
        win[k] <= win[k-1];
      end
    end
  end

  // Rank each entry; equal values are ordered by position so ranks are unique
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
    end
  end

  // Select the entry of middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MED_RANK) begin
        median = median | win[i];
      end
    end
  end

  assign res.median   = median;
  assign res.newest   = win[0];
  assign res.previous = win[1];

endmodule

FILE: sv/dsmf_merge.sv
// ----------------------------------------------------------------------------
// dsmf_merge
// Merge stage: combine both lane results into the flags and hold the item
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module dsmf_merge import dsmf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 stage_valid,
  input  lane_res_t            left_res,
  input  lane_res_t            right_res,
  output logic                 advance,
  dsmf_result_if.source        result
);

  logic                out_valid;
  sample_t             left_median;
  sample_t             right_median;
  logic                steer_flag;
  logic                move_flag;
  logic [SAMPLE_W:0]   sum_new;
  logic [SAMPLE_W:0]   sum_prev;
  logic                move_next;
  logic                steer_next;

  // Halved pair sums of the newest and the previous item
  assign sum_new    = {1'b0, left_res.newest} + {1'b0, right_res.newest};
  assign sum_prev   = {1'b0, left_res.previous} + {1'b0, right_res.previous};
  assign move_next  = (sum_new[SAMPLE_W:1] != sum_prev[SAMPLE_W:1]);
  assign steer_next = (left_res.median != right_res.median);

  // Output register frees up when empty or when its item is taken
  assign advance = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      left_median  <= left_res.median;
      right_median <= right_res.median;
      steer_flag   <= steer_next;
      move_flag    <= move_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.left_median  = left_median;
  assign result.right_median = right_median;
  assign result.steer_flag   = steer_flag;
  assign result.move_flag    = move_flag;

endmodule

FILE: sv/dual_sonar_median_filter_unit.sv
// ----------------------------------------------------------------------------
// dual_sonar_median_filter_unit
// Sliding median filter over a left and a right distance stream.
// ----------------------------------------------------------------------------
// The unit takes one item (a left and a right sample) per clock cycle while
// the output side keeps up, and returns one result per item, in order. An
// accepted item's clamped samples are shifted into the two windows; the
// output register then captures the medians and flags computed by the rank
// compare network of each lane, once it is free to take them.
// Throughput is one item per cycle whenever the output side keeps up; a
// stall on the result channel holds the window stage and then the input.
// The clamp limit register may be written only while no item is in flight.
module dual_sonar_median_filter_unit import dsmf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  sample_t          cfg_wr_data,
  dsmf_sample_if.sink      sample,
  dsmf_result_if.source    result
);

  sample_t    clamp_limit;
  logic       stage_valid;
  logic       advance;
  logic       accept;
  lane_res_t  left_res;
  lane_res_t  right_res;

  // Hold the clamp limit
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit <= CLAMP_RESET;
    end else if (cfg_wr_en) begin
      clamp_limit <= cfg_wr_data;
    end
  end

  // Take an item when the window stage is empty or moving on
  assign sample.ready = !stage_valid || advance;
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  dsmf_lane u_left (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (accept),
    .sample      (sample.left_sample),
    .clamp_limit (clamp_limit),
    .res         (left_res)
  );

  dsmf_lane u_right (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (accept),
    .sample      (sample.right_sample),
    .clamp_limit (clamp_limit),
    .res         (right_res)
  );

  dsmf_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .left_res    (left_res),
    .right_res   (right_res),
    .advance     (advance),
    .result      (result)
  );

`ifndef ASSERT_OFF
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted item did not reach the window stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> !sample.ready)
    else $error("input taken while the window stage is stalled");

  a_stage_moves_out: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && advance) |=> result.valid)
    else $error("window stage item lost on its way to the output");

  a_steer_matches: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.steer_flag == (result.left_median != result.right_median)))
    else $error("steer flag disagrees with the medians");
`endif

endmodule
